@@ sv/rtc_pkg.sv @@
// race timer controller package: codes, payload and state types, helpers
package rtc_pkg;

    localparam int RACER_BUTTONS_DEF = 4;
    localparam logic [15:0] ERR_TIMEOUT_RESET = 16'(10 * (100 + 100));
    localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] ERR_TICKS_MAX = 16'hFFFF;
    localparam logic [2:0] AUX_BUTTON = 3'd5;

    localparam logic [7:0] MODE_NONE = 8'd0;
    localparam logic [7:0] MODE_FOUR = 8'd1;
    localparam logic [7:0] MODE_ONE  = 8'd2;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_PRESS      = 3'd1,
        ACT_CMD        = 3'd2,
        ACT_CONNECT    = 3'd3,
        ACT_DISCONNECT = 3'd4
    } action_t;

    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_NEW      = 3'd1;
    localparam logic [2:0] CMD_CLEAR    = 3'd2;
    localparam logic [2:0] CMD_MODE_SEL = 3'd3;
    localparam logic [2:0] CMD_ECHO     = 3'd4;
    localparam logic [2:0] CMD_STATUS   = 3'd5;

    localparam logic [2:0] EV_ACK    = 3'd0;
    localparam logic [2:0] EV_STOP   = 3'd1;
    localparam logic [2:0] EV_DONE   = 3'd2;
    localparam logic [2:0] EV_STATUS = 3'd3;
    localparam logic [2:0] EV_PONG   = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    localparam logic [2:0] ERR_MODE_NOT_ALLOWED = 3'd0;
    localparam logic [2:0] ERR_INVALID          = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN          = 3'd2;

    localparam logic [2:0] CODE_DISC = 3'd0;
    localparam logic [2:0] CODE_IDLE = 3'd1;
    localparam logic [2:0] CODE_CONF = 3'd2;
    localparam logic [2:0] CODE_RUN  = 3'd3;
    localparam logic [2:0] CODE_FIN  = 3'd4;
    localparam logic [2:0] CODE_ERR  = 3'd5;

    typedef enum logic [5:0] {
        ST_DISC = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_CONF = 6'b000100,
        ST_RUN  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_ERR  = 6'b100000
    } st_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] button;
        logic [2:0] command;
        logic [7:0] requested_mode;
    } rtc_in_t;

    typedef struct packed {
        logic        event_valid;
        logic [2:0]  event_kind;
        logic [2:0]  event_detail;
        logic [31:0] event_time_ms;
        logic [7:0]  current_mode;
        logic [31:0] current_race_id;
        logic [2:0]  current_state;
        logic        last_result;
    } rtc_out_t;

    typedef struct packed {
        logic [1:0] n;
        rtc_out_t   r0;
        rtc_out_t   r1;
    } rtc_rows_t;

    typedef struct packed {
        st_t         st;
        logic        link_up;
        logic [7:0]  mode;
        logic [31:0] race_id;
        logic [31:0] uptime;
        logic [31:0] elapsed;
        logic        running;
        logic [2:0]  press_count;
        logic [2:0]  first_button;
        logic [31:0] first_time;
        logic [2:0]  win_button;
        logic [31:0] win_time;
        logic [15:0] err_ticks;
    } rtc_state_t;

    function automatic logic [2:0] state_code(input st_t st);
        logic [2:0] c;
        unique case (st)
            ST_DISC: c = CODE_DISC;
            ST_IDLE: c = CODE_IDLE;
            ST_CONF: c = CODE_CONF;
            ST_RUN:  c = CODE_RUN;
            ST_FIN:  c = CODE_FIN;
            ST_ERR:  c = CODE_ERR;
            default: c = CODE_DISC;
        endcase
        return c;
    endfunction

endpackage

@@ sv/rtc_core.sv @@
// race timer controller next-state and event logic for one input item
module rtc_core #(
    parameter int RACER_BUTTONS = rtc_pkg::RACER_BUTTONS_DEF
) (
    input  rtc_pkg::rtc_in_t           item,
    input  rtc_pkg::rtc_state_t        st_cur,
    input  logic [RACER_BUTTONS-1:0]   mask_cur,
    input  logic [15:0]                err_timeout,
    output rtc_pkg::rtc_state_t        st_new,
    output logic [RACER_BUTTONS-1:0]   mask_new,
    output rtc_pkg::rtc_rows_t         rows
);

    function automatic rtc_pkg::rtc_state_t go_state(input rtc_pkg::rtc_state_t s,
                                                     input rtc_pkg::st_t t);
        rtc_pkg::rtc_state_t r;
        r = s;
        if (r.st != t) begin
            r.st = t;
            if (t == rtc_pkg::ST_ERR) begin
                r.err_ticks = '0;
            end
        end
        return r;
    endfunction

    function automatic rtc_pkg::rtc_rows_t emit(input rtc_pkg::rtc_rows_t rw,
                                                input rtc_pkg::rtc_state_t s,
                                                input logic [2:0] kind,
                                                input logic [2:0] det,
                                                input logic [31:0] t);
        rtc_pkg::rtc_rows_t r;
        rtc_pkg::rtc_out_t  o;
        r = rw;
        o.event_valid     = 1'b1;
        o.event_kind      = kind;
        o.event_detail    = det;
        o.event_time_ms   = t;
        o.current_mode    = s.mode;
        o.current_race_id = s.race_id;
        o.current_state   = rtc_pkg::state_code(s.st);
        o.last_result     = 1'b0;
        if (s.link_up && r.n < 2'd2) begin
            if (r.n == 2'd0) begin
                r.r0 = o;
            end else begin
                r.r1 = o;
            end
            r.n = r.n + 2'd1;
        end
        return r;
    endfunction

    rtc_pkg::rtc_state_t      s;
    rtc_pkg::rtc_rows_t       rw;
    logic [RACER_BUTTONS-1:0] mk;
    logic [RACER_BUTTONS-1:0] bit_v;
    rtc_pkg::st_t             prev;
    logic                     want_start;
    logic                     want_new;
    logic                     want_stop;
    logic                     want_racer;
    logic [31:0]              e;

    always_comb begin
        s          = st_cur;
        mk         = mask_cur;
        rw         = '0;
        want_start = 1'b0;
        want_new   = 1'b0;
        want_stop  = 1'b0;
        want_racer = 1'b0;
        prev       = st_cur.st;
        e          = st_cur.elapsed;
        bit_v      = RACER_BUTTONS'(1) << (item.button - 3'd1);

        unique case (item.action)
            rtc_pkg::ACT_TICK: begin
                s.uptime = s.uptime + 32'd1;
                if (s.running && s.elapsed != rtc_pkg::ELAPSED_MAX) begin
                    s.elapsed = s.elapsed + 32'd1;
                end
                if (s.st == rtc_pkg::ST_ERR) begin
                    if (s.err_ticks != rtc_pkg::ERR_TICKS_MAX) begin
                        s.err_ticks = s.err_ticks + 16'd1;
                    end
                    if (s.err_ticks >= err_timeout) begin
                        s = go_state(s, rtc_pkg::ST_DISC);
                    end
                end
            end
            rtc_pkg::ACT_PRESS: begin
                if (item.button == rtc_pkg::AUX_BUTTON) begin
                    unique case (s.st)
                        rtc_pkg::ST_DISC, rtc_pkg::ST_IDLE: begin
                            s.mode     = rtc_pkg::MODE_FOUR;
                            s          = go_state(s, rtc_pkg::ST_CONF);
                            want_start = 1'b1;
                        end
                        rtc_pkg::ST_CONF: want_start = 1'b1;
                        rtc_pkg::ST_RUN:  want_stop  = 1'b1;
                        rtc_pkg::ST_FIN, rtc_pkg::ST_ERR: want_new = 1'b1;
                        default: ;
                    endcase
                end else if (s.st == rtc_pkg::ST_RUN && item.button >= 3'd1
                             && item.button <= 3'(RACER_BUTTONS)) begin
                    want_racer = 1'b1;
                end
            end
            rtc_pkg::ACT_CMD: begin
                unique case (item.command)
                    rtc_pkg::CMD_START: want_start = 1'b1;
                    rtc_pkg::CMD_NEW, rtc_pkg::CMD_CLEAR: want_new = 1'b1;
                    rtc_pkg::CMD_MODE_SEL: begin
                        if (s.st != rtc_pkg::ST_IDLE && s.st != rtc_pkg::ST_CONF) begin
                            rw = emit(rw, s, rtc_pkg::EV_ERROR,
                                      rtc_pkg::ERR_MODE_NOT_ALLOWED, 32'd0);
                        end else if (item.requested_mode != rtc_pkg::MODE_FOUR
                                     && item.requested_mode != rtc_pkg::MODE_ONE) begin
                            rw = emit(rw, s, rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID, 32'd0);
                        end else begin
                            s.mode = item.requested_mode;
                            s      = go_state(s, rtc_pkg::ST_CONF);
                        end
                    end
                    rtc_pkg::CMD_ECHO:   rw = emit(rw, s, rtc_pkg::EV_PONG, 3'd0, 32'd0);
                    rtc_pkg::CMD_STATUS: rw = emit(rw, s, rtc_pkg::EV_STATUS, 3'd0, s.elapsed);
                    default: rw = emit(rw, s, rtc_pkg::EV_ERROR, rtc_pkg::ERR_UNKNOWN, 32'd0);
                endcase
            end
            rtc_pkg::ACT_CONNECT: begin
                s.link_up = 1'b1;
                if (s.st == rtc_pkg::ST_DISC) begin
                    s = go_state(s, rtc_pkg::ST_IDLE);
                end else if (s.st == rtc_pkg::ST_ERR) begin
                    if (s.running) begin
                        s  = go_state(s, rtc_pkg::ST_RUN);
                        rw = emit(rw, s, rtc_pkg::EV_STATUS, 3'd0, s.elapsed);
                    end else begin
                        s = go_state(s, rtc_pkg::ST_IDLE);
                    end
                end
            end
            rtc_pkg::ACT_DISCONNECT: begin
                s.link_up = 1'b0;
                if (s.st == rtc_pkg::ST_RUN) begin
                    s = go_state(s, rtc_pkg::ST_ERR);
                end else begin
                    s = go_state(s, rtc_pkg::ST_DISC);
                end
            end
            default: ;
        endcase

        // start of a race, only from configured
        if (want_start) begin
            if (s.st != rtc_pkg::ST_CONF) begin
                rw = emit(rw, s, rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID, 32'd0);
            end else begin
                if (s.mode != rtc_pkg::MODE_FOUR && s.mode != rtc_pkg::MODE_ONE) begin
                    s.mode = rtc_pkg::MODE_FOUR;
                end
                s.race_id      = s.uptime;
                mk             = '0;
                s.press_count  = '0;
                s.first_button = '0;
                s.first_time   = '0;
                s.win_button   = '0;
                s.win_time     = '0;
                s.elapsed      = '0;
                s.running      = 1'b1;
                s              = go_state(s, rtc_pkg::ST_RUN);
                rw             = emit(rw, s, rtc_pkg::EV_ACK, 3'd0, 32'd0);
            end
        end

        if (want_new) begin
            s.running      = 1'b0;
            s.elapsed      = '0;
            mk             = '0;
            s.press_count  = '0;
            s.first_button = '0;
            s.first_time   = '0;
            s.win_button   = '0;
            s.win_time     = '0;
            s.mode         = rtc_pkg::MODE_NONE;
            s.race_id      = '0;
            if (prev != rtc_pkg::ST_ERR && s.link_up) begin
                s = go_state(s, rtc_pkg::ST_IDLE);
            end else begin
                s = go_state(s, rtc_pkg::ST_DISC);
            end
        end

        if (want_stop) begin
            s.running = 1'b0;
            if (s.win_button == 3'd0) begin
                if (s.press_count != 3'd0) begin
                    s.win_button = s.first_button;
                    s.win_time   = s.first_time;
                end else begin
                    s.win_time = e;
                end
            end
            s = go_state(s, rtc_pkg::ST_FIN);
            if (s.win_button != 3'd0) begin
                rw = emit(rw, s, rtc_pkg::EV_DONE, s.win_button, s.win_time);
            end else begin
                rw = emit(rw, s, rtc_pkg::EV_DONE, 3'd0, e);
            end
        end

        if (want_racer && (mk & bit_v) == '0) begin
            if (s.press_count == 3'd0) begin
                s.first_button = item.button;
                s.first_time   = e;
            end
            mk            = mk | bit_v;
            s.press_count = s.press_count + 3'd1;
            rw            = emit(rw, s, rtc_pkg::EV_STOP, item.button, e);
            if (s.mode == rtc_pkg::MODE_FOUR) begin
                if (s.win_button == 3'd0) begin
                    s.win_button = item.button;
                    s.win_time   = e;
                end
                if (s.press_count >= 3'(RACER_BUTTONS)) begin
                    s.running = 1'b0;
                    s         = go_state(s, rtc_pkg::ST_FIN);
                    rw        = emit(rw, s, rtc_pkg::EV_DONE, s.win_button, s.win_time);
                end
            end else if (s.mode == rtc_pkg::MODE_ONE) begin
                if (s.press_count >= 3'(RACER_BUTTONS)) begin
                    s.win_button = item.button;
                    s.win_time   = e;
                    s.running    = 1'b0;
                    s            = go_state(s, rtc_pkg::ST_FIN);
                    rw           = emit(rw, s, rtc_pkg::EV_DONE, 3'd0, e);
                end
            end
        end

        // no event: one plain status item
        if (rw.n == 2'd0) begin
            rw.r0.event_valid     = 1'b0;
            rw.r0.event_kind      = 3'd0;
            rw.r0.event_detail    = 3'd0;
            rw.r0.event_time_ms   = 32'd0;
            rw.r0.current_mode    = s.mode;
            rw.r0.current_race_id = s.race_id;
            rw.r0.current_state   = rtc_pkg::state_code(s.st);
            rw.n                  = 2'd1;
        end
        if (rw.n == 2'd1) begin
            rw.r0.last_result = 1'b1;
        end else begin
            rw.r1.last_result = 1'b1;
        end

        st_new   = s;
        mask_new = mk;
        rows     = rw;
    end

endmodule

@@ sv/race_timer_controller_unit.sv @@
// race timer controller top level: input stage, state registers, result buffer
//
// Each accepted input item waits in the input stage, where the whole state update and its
// result items are worked out; once it executes, its results are registered and appear on
// the result channel in the next cycle. An item that yields one result lets the next item
// follow every cycle while the receiver is ready; an item that yields two results fills the
// two-entry result buffer, so the next item waits until the first is read. Events are only
// produced while the link is up; every item ends with a transfer that has last_result set.
module race_timer_controller_unit #(
    parameter int RACER_BUTTONS = rtc_pkg::RACER_BUTTONS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rtc_pkg::rtc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rtc_pkg::rtc_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    rtc_pkg::rtc_in_t         in_data_reg, in_data_next;
    logic                     in_valid_reg, in_valid_next;
    rtc_pkg::rtc_state_t      st_reg, st_next;
    logic [RACER_BUTTONS-1:0] mask_reg, mask_next;
    logic [15:0]              timeout_reg, timeout_next;
    rtc_pkg::rtc_out_t        row0_reg, row0_next;
    rtc_pkg::rtc_out_t        row1_reg, row1_next;
    logic [1:0]               count_reg, count_next;

    rtc_pkg::rtc_state_t      core_st;
    logic [RACER_BUTTONS-1:0] core_mask;
    rtc_pkg::rtc_rows_t       core_rows;
    logic                     exec;
    logic                     pop;

    rtc_core #(
        .RACER_BUTTONS(RACER_BUTTONS)
    ) u_core (
        .item        (in_data_reg),
        .st_cur      (st_reg),
        .mask_cur    (mask_reg),
        .err_timeout (timeout_reg),
        .st_new      (core_st),
        .mask_new    (core_mask),
        .rows        (core_rows)
    );

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = row0_reg;
    assign pop     = m_valid && m_ready;
    assign exec    = in_valid_reg
                     && (count_reg == 2'd0 || (count_reg == 2'd1 && m_ready));
    assign s_ready = !in_valid_reg || exec;

    always_comb begin
        in_data_next  = in_data_reg;
        in_valid_next = in_valid_reg;
        st_next       = st_reg;
        mask_next     = mask_reg;
        timeout_next  = timeout_reg;
        row0_next     = row0_reg;
        row1_next     = row1_reg;
        count_next    = count_reg;

        if (s_valid && s_ready) begin
            in_data_next  = s_data;
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end

        if (exec) begin
            st_next    = core_st;
            mask_next  = core_mask;
            row0_next  = core_rows.r0;
            row1_next  = core_rows.r1;
            count_next = core_rows.n;
        end else if (pop) begin
            row0_next  = row1_reg;
            count_next = count_reg - 2'd1;
        end

        if (cfg_wr_en) begin
            timeout_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= 2'd0;
            timeout_reg  <= rtc_pkg::ERR_TIMEOUT_RESET;
            mask_reg     <= '0;
            st_reg       <= '{st: rtc_pkg::ST_DISC, default: '0};
        end else begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            timeout_reg  <= timeout_next;
            mask_reg     <= mask_next;
            st_reg       <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        row0_reg    <= row0_next;
        row1_reg    <= row1_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_first_of_two_is_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last_result) |-> m_data.event_valid)
        else $error("non-final transfer without an event");

    a_no_exec_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !exec)
        else $error("input stage executed into a full result buffer");

    a_err_entry_clears_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && st_reg.st != rtc_pkg::ST_ERR && core_st.st == rtc_pkg::ST_ERR)
        |=> st_reg.err_ticks == 16'd0)
        else $error("error tick count not cleared on entry to error");

endmodule

@@ verif/race_timer_controller_unit_tb.sv @@
// race timer controller testbench: directed table and random traffic checked against a predictor
module race_timer_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD     = 4;
    localparam int          RESET_CYCLES    = 12;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          PHASE_ITEMS     = 250;
    localparam int          ERR_PROBE_TICKS = 16;
    localparam int          WATCHDOG_NS     = 40_000_000;
    localparam logic [2:0]  CMD_UNKNOWN     = 3'd6;
    localparam logic [2:0]  CMD_SPARE       = 3'd7;
    localparam logic [2:0]  ACT_SPARE       = 3'd7;
    localparam logic [15:0] LIMIT_MAX       = 16'hFFFF;

    typedef struct {
        rtc_pkg::rtc_in_t  stim;
        bit                typed;
        rtc_pkg::rtc_out_t want;
    } plan_row_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    rtc_pkg::rtc_in_t  s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    rtc_pkg::rtc_out_t m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [15:0]       cfg_wr_data = '0;

    // timer state as the host should see it
    logic [2:0]  tm_state     = rtc_pkg::CODE_DISC;
    logic        tm_link      = 1'b0;
    logic [7:0]  tm_mode      = rtc_pkg::MODE_NONE;
    logic [31:0] tm_race_id   = '0;
    logic [31:0] tm_uptime    = '0;
    logic [31:0] tm_elapsed   = '0;
    logic        tm_running   = 1'b0;
    logic [3:0]  tm_pressed   = '0;
    logic [2:0]  tm_presses   = '0;
    logic [2:0]  tm_first_btn = '0;
    logic [31:0] tm_first_ms  = '0;
    logic [2:0]  tm_win_btn   = '0;
    logic [31:0] tm_win_ms    = '0;
    logic [15:0] tm_err_ticks = '0;
    logic [15:0] tm_err_limit = rtc_pkg::ERR_TIMEOUT_RESET;

    rtc_pkg::rtc_out_t fresh_events[2];
    int                fresh_count;
    rtc_pkg::rtc_out_t pending_results[$];
    int                fault_count = 0;
    int                burst_left  = 0;
    int                idle_gap    = 0;
    logic [7:0]        stall_cyc   = '0;
    logic [1:0]        stall_mode  = '0;

    always #(HALF_PERIOD) aclk = ~aclk;

    race_timer_controller_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic void enter_state(logic [2:0] s);
        if (tm_state != s) begin
            tm_state = s;
            if (s == rtc_pkg::CODE_ERR) tm_err_ticks = '0;
        end
    endfunction

    function automatic rtc_pkg::rtc_out_t snapshot(logic v, logic [2:0] kind, logic [2:0] det,
                                                   logic [31:0] t);
        rtc_pkg::rtc_out_t r;
        r.event_valid     = v;
        r.event_kind      = kind;
        r.event_detail    = det;
        r.event_time_ms   = t;
        r.current_mode    = tm_mode;
        r.current_race_id = tm_race_id;
        r.current_state   = tm_state;
        r.last_result     = 1'b0;
        return r;
    endfunction

    // events reach the host only while the link is up
    function automatic void announce(logic [2:0] kind, logic [2:0] det, logic [31:0] t);
        if (tm_link && fresh_count < 2) begin
            fresh_events[fresh_count] = snapshot(1'b1, kind, det, t);
            fresh_count++;
        end
    endfunction

    function automatic void clear_race();
        tm_pressed   = '0;
        tm_presses   = '0;
        tm_first_btn = '0;
        tm_first_ms  = '0;
        tm_win_btn   = '0;
        tm_win_ms    = '0;
    endfunction

    function automatic void begin_race();
        if (tm_state != rtc_pkg::CODE_CONF) begin
            announce(rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID, '0);
            return;
        end
        if (tm_mode != rtc_pkg::MODE_FOUR && tm_mode != rtc_pkg::MODE_ONE)
            tm_mode = rtc_pkg::MODE_FOUR;
        tm_race_id = tm_uptime;
        clear_race();
        tm_elapsed = '0;
        tm_running = 1'b1;
        enter_state(rtc_pkg::CODE_RUN);
        announce(rtc_pkg::EV_ACK, '0, '0);
    endfunction

    function automatic void abandon_race();
        logic [2:0] prev;
        prev       = tm_state;
        tm_running = 1'b0;
        tm_elapsed = '0;
        clear_race();
        tm_mode    = rtc_pkg::MODE_NONE;
        tm_race_id = '0;
        if (prev != rtc_pkg::CODE_ERR && tm_link) enter_state(rtc_pkg::CODE_IDLE);
        else enter_state(rtc_pkg::CODE_DISC);
    endfunction

    function automatic void end_race();
        logic [31:0] e;
        e          = tm_elapsed;
        tm_running = 1'b0;
        if (tm_win_btn == 0) begin
            if (tm_presses > 0) begin
                tm_win_btn = tm_first_btn;
                tm_win_ms  = tm_first_ms;
            end else begin
                tm_win_ms = e;
            end
        end
        enter_state(rtc_pkg::CODE_FIN);
        if (tm_win_btn > 0) announce(rtc_pkg::EV_DONE, tm_win_btn, tm_win_ms);
        else announce(rtc_pkg::EV_DONE, '0, e);
    endfunction

    function automatic void racer_hit(logic [2:0] b);
        logic [31:0] e;
        logic [3:0]  hit_mask;
        e        = tm_elapsed;
        hit_mask = 4'b0001 << (b - 3'd1);
        if ((tm_pressed & hit_mask) != 0) return;
        if (tm_presses == 0) begin
            tm_first_btn = b;
            tm_first_ms  = e;
        end
        tm_pressed = tm_pressed | hit_mask;
        tm_presses = tm_presses + 3'd1;
        announce(rtc_pkg::EV_STOP, b, e);
        if (tm_mode == rtc_pkg::MODE_FOUR) begin
            if (tm_win_btn == 0) begin
                tm_win_btn = b;
                tm_win_ms  = e;
            end
            if (tm_presses >= rtc_pkg::RACER_BUTTONS_DEF) begin
                tm_running = 1'b0;
                enter_state(rtc_pkg::CODE_FIN);
                announce(rtc_pkg::EV_DONE, tm_win_btn, tm_win_ms);
            end
        end else if (tm_mode == rtc_pkg::MODE_ONE) begin
            if (tm_presses >= rtc_pkg::RACER_BUTTONS_DEF) begin
                tm_win_btn = b;
                tm_win_ms  = e;
                tm_running = 1'b0;
                enter_state(rtc_pkg::CODE_FIN);
                announce(rtc_pkg::EV_DONE, '0, e);
            end
        end
    endfunction

    function automatic void start_stop();
        case (tm_state)
            rtc_pkg::CODE_DISC, rtc_pkg::CODE_IDLE: begin
                tm_mode = rtc_pkg::MODE_FOUR;
                enter_state(rtc_pkg::CODE_CONF);
                begin_race();
            end
            rtc_pkg::CODE_CONF: begin_race();
            rtc_pkg::CODE_RUN: end_race();
            rtc_pkg::CODE_FIN, rtc_pkg::CODE_ERR: abandon_race();
            default: ;
        endcase
    endfunction

    function automatic void count_tick();
        tm_uptime = tm_uptime + 32'd1;
        if (tm_running && tm_elapsed != rtc_pkg::ELAPSED_MAX) tm_elapsed = tm_elapsed + 32'd1;
        if (tm_state == rtc_pkg::CODE_ERR) begin
            if (tm_err_ticks != rtc_pkg::ERR_TICKS_MAX) tm_err_ticks = tm_err_ticks + 16'd1;
            if (tm_err_ticks >= tm_err_limit) enter_state(rtc_pkg::CODE_DISC);
        end
    endfunction

    function automatic void host_command(logic [2:0] c, logic [7:0] m);
        case (c)
            rtc_pkg::CMD_START: begin_race();
            rtc_pkg::CMD_NEW, rtc_pkg::CMD_CLEAR: abandon_race();
            rtc_pkg::CMD_MODE_SEL: begin
                if (tm_state != rtc_pkg::CODE_IDLE && tm_state != rtc_pkg::CODE_CONF) begin
                    announce(rtc_pkg::EV_ERROR, rtc_pkg::ERR_MODE_NOT_ALLOWED, '0);
                end else if (m != rtc_pkg::MODE_FOUR && m != rtc_pkg::MODE_ONE) begin
                    announce(rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID, '0);
                end else begin
                    tm_mode = m;
                    enter_state(rtc_pkg::CODE_CONF);
                end
            end
            rtc_pkg::CMD_ECHO: announce(rtc_pkg::EV_PONG, '0, '0);
            rtc_pkg::CMD_STATUS: announce(rtc_pkg::EV_STATUS, '0, tm_elapsed);
            default: announce(rtc_pkg::EV_ERROR, rtc_pkg::ERR_UNKNOWN, '0);
        endcase
    endfunction

    function automatic void predict_results(rtc_pkg::rtc_in_t it);
        fresh_count = 0;
        case (it.action)
            rtc_pkg::ACT_TICK: count_tick();
            rtc_pkg::ACT_PRESS: begin
                if (it.button == rtc_pkg::AUX_BUTTON) start_stop();
                else if (tm_state == rtc_pkg::CODE_RUN && it.button >= 1
                         && it.button <= rtc_pkg::RACER_BUTTONS_DEF) racer_hit(it.button);
            end
            rtc_pkg::ACT_CMD: host_command(it.command, it.requested_mode);
            rtc_pkg::ACT_CONNECT: begin
                tm_link = 1'b1;
                if (tm_state == rtc_pkg::CODE_DISC) begin
                    enter_state(rtc_pkg::CODE_IDLE);
                end else if (tm_state == rtc_pkg::CODE_ERR) begin
                    if (tm_running) begin
                        enter_state(rtc_pkg::CODE_RUN);
                        announce(rtc_pkg::EV_STATUS, '0, tm_elapsed);
                    end else begin
                        enter_state(rtc_pkg::CODE_IDLE);
                    end
                end
            end
            rtc_pkg::ACT_DISCONNECT: begin
                tm_link = 1'b0;
                if (tm_state == rtc_pkg::CODE_RUN) enter_state(rtc_pkg::CODE_ERR);
                else enter_state(rtc_pkg::CODE_DISC);
            end
            default: ;
        endcase
        if (fresh_count == 0) begin
            fresh_events[0] = snapshot(1'b0, '0, '0, '0);
            fresh_count     = 1;
        end
        fresh_events[fresh_count - 1].last_result = 1'b1;
    endfunction

    function automatic rtc_pkg::rtc_in_t compose(logic [2:0] act, logic [2:0] btn,
                                                 logic [2:0] cmd, logic [7:0] mode);
        rtc_pkg::rtc_in_t it;
        it.action         = act;
        it.button         = btn;
        it.command        = cmd;
        it.requested_mode = mode;
        return it;
    endfunction

    function automatic plan_row_t open_row(rtc_pkg::rtc_in_t it);
        plan_row_t r;
        r.stim  = it;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // single-transfer result before any race has started
    function automatic plan_row_t fixed_row(rtc_pkg::rtc_in_t it, logic v, logic [2:0] kind,
                                            logic [2:0] det, logic [7:0] mode, logic [2:0] st);
        plan_row_t r;
        r.stim                 = it;
        r.typed                = 1'b1;
        r.want                 = '0;
        r.want.event_valid     = v;
        r.want.event_kind      = kind;
        r.want.event_detail    = det;
        r.want.current_mode    = mode;
        r.want.current_state   = st;
        r.want.last_result     = 1'b1;
        return r;
    endfunction

    // mostly well-formed race traffic, some noise
    function automatic rtc_pkg::rtc_in_t roll_item();
        rtc_pkg::rtc_in_t it;
        int               r;
        int               pick;
        it.action         = 3'($urandom_range(0, 7));
        it.button         = 3'($urandom_range(0, 7));
        it.command        = 3'($urandom_range(0, 7));
        it.requested_mode = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 30) begin
            it.action = rtc_pkg::ACT_TICK;
        end else if (r < 55) begin
            it.action = rtc_pkg::ACT_PRESS;
            if (tm_state == rtc_pkg::CODE_RUN && $urandom_range(0, 9) < 7)
                it.button = 3'($urandom_range(1, 4));
            else if ($urandom_range(0, 3) != 0) it.button = rtc_pkg::AUX_BUTTON;
        end else if (r < 78) begin
            it.action = rtc_pkg::ACT_CMD;
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                it.command = rtc_pkg::CMD_MODE_SEL;
                if ($urandom_range(0, 3) != 0)
                    it.requested_mode = $urandom_range(0, 1) ? rtc_pkg::MODE_FOUR
                                                             : rtc_pkg::MODE_ONE;
            end else if (pick < 5) begin
                it.command = rtc_pkg::CMD_START;
            end else if (pick == 5) begin
                it.command = rtc_pkg::CMD_NEW;
            end else if (pick == 6) begin
                it.command = rtc_pkg::CMD_CLEAR;
            end else if (pick == 7) begin
                it.command = rtc_pkg::CMD_ECHO;
            end else if (pick == 8) begin
                it.command = rtc_pkg::CMD_STATUS;
            end
        end else if (r < 88) begin
            it.action = rtc_pkg::ACT_CONNECT;
        end else if (r < 96) begin
            it.action = rtc_pkg::ACT_DISCONNECT;
        end
        return it;
    endfunction

    task automatic apply(rtc_pkg::rtc_in_t it, bit typed, rtc_pkg::rtc_out_t want);
        if (idle_gap > 0) begin
            s_valid <= 1'b0;
            repeat (idle_gap) @(posedge aclk);
            idle_gap = 0;
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_results(it);
        if (typed) pending_results.push_back(want);
        else for (int k = 0; k < fresh_count; k++) pending_results.push_back(fresh_events[k]);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [15:0] limit);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        tm_err_limit = limit;
    endtask

    task automatic match_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
            fault_count++;
        end
    endtask

    // receiver stalls in modes picked anew each time the 8-bit stall counter wraps
    always @(posedge aclk) begin
        stall_cyc <= stall_cyc + 8'd1;
        if (stall_cyc == 8'hFF) stall_mode <= 2'($urandom_range(0, 2));
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (stall_cyc[2:0] < 3'd5);
        endcase
    end

    always @(posedge aclk) begin
        rtc_pkg::rtc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, m_data);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                match_field("event_valid", 32'(want.event_valid), 32'(m_data.event_valid));
                match_field("event_kind", 32'(want.event_kind), 32'(m_data.event_kind));
                match_field("event_detail", 32'(want.event_detail), 32'(m_data.event_detail));
                match_field("event_time_ms", want.event_time_ms, m_data.event_time_ms);
                match_field("current_mode", 32'(want.current_mode), 32'(m_data.current_mode));
                match_field("current_race_id", want.current_race_id, m_data.current_race_id);
                match_field("current_state", 32'(want.current_state),
                            32'(m_data.current_state));
                match_field("last_result", 32'(want.last_result), 32'(m_data.last_result));
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        plan_row_t   plan[$];
        logic [15:0] limit;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_ECHO, '0),
                                 1'b0, '0, '0, rtc_pkg::MODE_NONE, rtc_pkg::CODE_DISC));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CONNECT, '0, '0, '0),
                                 1'b0, '0, '0, rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_ECHO, '0),
                                 1'b1, rtc_pkg::EV_PONG, '0, rtc_pkg::MODE_NONE,
                                 rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, CMD_UNKNOWN, '0),
                                 1'b1, rtc_pkg::EV_ERROR, rtc_pkg::ERR_UNKNOWN,
                                 rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, 3'd7, CMD_SPARE, 8'hFF),
                                 1'b1, rtc_pkg::EV_ERROR, rtc_pkg::ERR_UNKNOWN,
                                 rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_MODE_SEL,
                                         rtc_pkg::MODE_NONE),
                                 1'b1, rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID,
                                 rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_MODE_SEL, 8'hFF),
                                 1'b1, rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID,
                                 rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_START, '0),
                                 1'b1, rtc_pkg::EV_ERROR, rtc_pkg::ERR_INVALID,
                                 rtc_pkg::MODE_NONE, rtc_pkg::CODE_IDLE));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_MODE_SEL,
                                         rtc_pkg::MODE_ONE),
                                 1'b0, '0, '0, rtc_pkg::MODE_ONE, rtc_pkg::CODE_CONF));
        plan.push_back(fixed_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_MODE_SEL,
                                         rtc_pkg::MODE_FOUR),
                                 1'b0, '0, '0, rtc_pkg::MODE_FOUR, rtc_pkg::CODE_CONF));
        plan.push_back(open_row(compose(rtc_pkg::ACT_TICK, '0, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_START, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_TICK, 3'd7, 3'd7, 8'hFF)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd0, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd7, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd3, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd3, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_MODE_SEL,
                                        rtc_pkg::MODE_FOUR)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_STATUS, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd1, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd2, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, 3'd4, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, rtc_pkg::AUX_BUTTON, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, rtc_pkg::AUX_BUTTON, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_DISCONNECT, '0, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_TICK, '0, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_CONNECT, '0, '0, '0)));
        plan.push_back(open_row(compose(ACT_SPARE, 3'd7, 3'd7, 8'hFF)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_PRESS, rtc_pkg::AUX_BUTTON, '0, '0)));
        plan.push_back(open_row(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_CLEAR, '0)));

        foreach (plan[i]) apply(plan[i].stim, plan[i].typed, plan[i].want);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: limit = rtc_pkg::ERR_TIMEOUT_RESET;
                1: limit = 16'd3;
                2: limit = 16'd0;
                3: limit = 16'd1;
                4: limit = LIMIT_MAX;
                default: limit = 16'($urandom_range(2, 50));
            endcase
            if (p > 0) set_timeout(limit);
            if (limit == LIMIT_MAX) begin
                // hold a broken link in error under the longest timeout
                apply(compose(rtc_pkg::ACT_CONNECT, '0, '0, '0), 1'b0, '0);
                apply(compose(rtc_pkg::ACT_CMD, '0, rtc_pkg::CMD_NEW, '0), 1'b0, '0);
                apply(compose(rtc_pkg::ACT_PRESS, rtc_pkg::AUX_BUTTON, '0, '0), 1'b0, '0);
                apply(compose(rtc_pkg::ACT_DISCONNECT, '0, '0, '0), 1'b0, '0);
                repeat (ERR_PROBE_TICKS)
                    apply(compose(rtc_pkg::ACT_TICK, '0, '0, '0), 1'b0, '0);
            end
            repeat (PHASE_ITEMS) apply(roll_item(), 1'b0, '0);
        end

        drain();
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ race_timer_controller_unit.f @@
sv/rtc_pkg.sv
sv/rtc_core.sv
sv/race_timer_controller_unit.sv
verif/race_timer_controller_unit_tb.sv
